>>> design/cwf_pkg.sv
// cwf_pkg: shared types, constants and helpers for the case-insensitive word filter.
// No dependencies; used by every module of the block.
package cwf_pkg;

    localparam int MAX_WORD = 16;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = $clog2(MAX_WORD + 1);
    localparam int IDX_W    = $clog2(MAX_WORD);
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PLEN_W   = 5;

    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [CHAR_W-1:0] UPPER_A      = 8'd65;
    localparam logic [CHAR_W-1:0] UPPER_Z      = 8'd90;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_TAIL,
        ST_EOL
    } state_t;

    // per-cell control: shift towards the head, or load the new character
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

>>> design/case_insensitive_word_filter_unit.sv
// Case-insensitive word filter: drops words equal to the pattern, keeps the rest.
// A streamed character or bare newline shows on m_ in the cycle after acceptance; a drained
// word goes through ST_DRAIN, then the output register. One request per cycle while idle
// and m_ is free; s_tready is low while a kept word and its tail or an overflowed buffer
// is sent, one character per cycle while m_ is free. Reset: aresetn, synchronous, active
// low; clears control state and pattern registers (length to 1), not the buffered characters.
module case_insensitive_word_filter_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] in_char
    input  logic                            s_tlast,   // line_end
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] out_char
    output logic                            m_tlast,   // out_last
    // configuration
    input  logic                            cfg_we,
    input  logic [cwf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cwf_pkg::CFG_W-1:0]       cfg_data
);

    // pattern registers
    logic [cwf_pkg::CFG_W-1:0]  pat_low_reg;
    logic [cwf_pkg::CFG_W-1:0]  pat_high_reg;
    logic [cwf_pkg::PLEN_W-1:0] pat_len_reg;

    // word tracking
    cwf_pkg::state_t            state_reg, state_next;
    logic [cwf_pkg::CNT_W-1:0]  word_count_reg, word_count_next;
    logic                       match_reg, match_next;
    logic                       pass_reg, pass_next;
    logic [cwf_pkg::CNT_W-1:0]  drain_cnt_reg, drain_cnt_next;
    logic [cwf_pkg::CHAR_W-1:0] tail_char_reg, tail_char_next;
    logic                       eol_reg, eol_next;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic [cwf_pkg::CHAR_W-1:0] m_data_reg, m_data_next;
    logic                       m_last_reg, m_last_next;

    // chain control
    logic                       chain_shift;
    logic                       chain_load;
    logic [cwf_pkg::CHAR_W-1:0] chain_head;

    logic                       out_free;
    logic                       accept;
    logic                       is_space;
    logic                       closing;
    logic                       word_full;
    logic                       word_keep;
    logic [cwf_pkg::IDX_W-1:0]  wr_idx;
    logic [cwf_pkg::CFG_W-1:0]  pat_word;
    logic [cwf_pkg::CHAR_W-1:0] pat_char;
    logic                       char_hit;

    // the output slot may be refilled when empty or being taken this cycle
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == cwf_pkg::ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign is_space  = (s_tdata == cwf_pkg::SPACE_CHAR);
    assign closing   = s_tlast || is_space;
    assign word_full = (word_count_reg == cwf_pkg::CNT_W'(cwf_pkg::MAX_WORD));
    // a non-empty word survives unless every character matched and lengths agree;
    // a pattern length beyond the buffer never equals the count
    assign word_keep = (word_count_reg != '0) &&
                       !(match_reg && (word_count_reg == cwf_pkg::CNT_W'(pat_len_reg)));

    // pattern character at the current write position
    assign wr_idx   = word_count_reg[cwf_pkg::IDX_W-1:0];
    assign pat_word = wr_idx[cwf_pkg::IDX_W-1] ? pat_high_reg : pat_low_reg;
    assign pat_char = pat_word[wr_idx[2:0]*cwf_pkg::CHAR_W +: cwf_pkg::CHAR_W];
    assign char_hit = (cwf_pkg::fold(s_tdata) == cwf_pkg::fold(pat_char)) &&
                      (word_count_reg < cwf_pkg::CNT_W'(pat_len_reg));

    cwf_chain u_chain (
        .aclk      (aclk),
        .shift     (chain_shift),
        .load_en   (chain_load),
        .load_idx  (wr_idx),
        .load_data (s_tdata),
        .head      (chain_head)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cwf_pkg::ST_IDLE: begin
                if (accept) begin
                    if (closing) begin
                        if (pass_reg) begin
                            state_next = cwf_pkg::ST_TAIL;
                        end else if (word_keep) begin
                            state_next = cwf_pkg::ST_DRAIN;
                        end
                    end else if (!pass_reg && word_full) begin
                        state_next = cwf_pkg::ST_DRAIN;
                    end
                end
            end
            cwf_pkg::ST_DRAIN: begin
                if (out_free && drain_cnt_reg == cwf_pkg::CNT_W'(1)) begin
                    state_next = cwf_pkg::ST_TAIL;
                end
            end
            cwf_pkg::ST_TAIL: begin
                if (out_free) begin
                    state_next = eol_reg ? cwf_pkg::ST_EOL : cwf_pkg::ST_IDLE;
                end
            end
            cwf_pkg::ST_EOL: begin
                if (out_free) begin
                    state_next = cwf_pkg::ST_IDLE;
                end
            end
            default: state_next = cwf_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        word_count_next = word_count_reg;
        match_next      = match_reg;
        pass_next       = pass_reg;
        drain_cnt_next  = drain_cnt_reg;
        tail_char_next  = tail_char_reg;
        eol_next        = eol_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        chain_shift     = 1'b0;
        chain_load      = 1'b0;

        unique case (state_reg)
            cwf_pkg::ST_IDLE: begin
                if (accept) begin
                    if (closing) begin
                        // word ends: clear tracking, schedule what is to be emitted
                        word_count_next = '0;
                        match_next      = 1'b1;
                        pass_next       = 1'b0;
                        tail_char_next  = cwf_pkg::SPACE_CHAR;
                        eol_next        = s_tlast;
                        drain_cnt_next  = word_count_reg;
                        if (!pass_reg && !word_keep && s_tlast) begin
                            m_valid_next = 1'b1;
                            m_data_next  = cwf_pkg::NEWLINE_CHAR;
                            m_last_next  = 1'b1;
                        end
                    end else if (pass_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next  = s_tdata;
                        m_last_next  = 1'b0;
                    end else if (word_full) begin
                        // overlong word: flush buffer, this character follows it
                        drain_cnt_next = cwf_pkg::CNT_W'(cwf_pkg::MAX_WORD);
                        tail_char_next = s_tdata;
                        eol_next       = 1'b0;
                        pass_next      = 1'b1;
                        match_next     = 1'b0;
                    end else begin
                        chain_load      = 1'b1;
                        word_count_next = word_count_reg + 1'b1;
                        match_next      = match_reg && char_hit;
                    end
                end
            end
            cwf_pkg::ST_DRAIN: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_data_next    = chain_head;
                    m_last_next    = 1'b0;
                    chain_shift    = 1'b1;
                    drain_cnt_next = drain_cnt_reg - 1'b1;
                end
            end
            cwf_pkg::ST_TAIL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = tail_char_reg;
                    m_last_next  = 1'b0;
                end
            end
            cwf_pkg::ST_EOL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = cwf_pkg::NEWLINE_CHAR;
                    m_last_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cwf_pkg::ST_IDLE;
            word_count_reg <= '0;
            match_reg      <= 1'b1;
            pass_reg       <= 1'b0;
            drain_cnt_reg  <= '0;
            eol_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            pat_low_reg    <= '0;
            pat_high_reg   <= '0;
            pat_len_reg    <= cwf_pkg::PLEN_W'(1);
        end else begin
            state_reg      <= state_next;
            word_count_reg <= word_count_next;
            match_reg      <= match_next;
            pass_reg       <= pass_next;
            drain_cnt_reg  <= drain_cnt_next;
            eol_reg        <= eol_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    cwf_pkg::REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                    cwf_pkg::REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                    cwf_pkg::REG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[cwf_pkg::PLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        tail_char_reg <= tail_char_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    // buffer count never runs past the chain length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        word_count_reg <= cwf_pkg::CNT_W'(cwf_pkg::MAX_WORD))
        else $error("word count beyond buffer");

    // streaming mode only after a full buffer, and such a word never matches
    a_pass_full: assert property (@(posedge aclk) disable iff (!aresetn)
        pass_reg |-> (word_full && !match_reg))
        else $error("pass-through without full buffer");

    // draining always has characters left
    a_drain_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cwf_pkg::ST_DRAIN) |-> (drain_cnt_reg != '0))
        else $error("drain with empty count");

    // last flag only on the newline
    a_last_nl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_data_reg == cwf_pkg::NEWLINE_CHAR))
        else $error("last marker on non-newline");
`endif

endmodule

>>> design/cwf_cell.sv
// cwf_cell: one character slot of the word buffer chain.
// Depends on cwf_pkg (cell_ctl_t, CHAR_W).
module cwf_cell (
    input  logic                        aclk,
    input  cwf_pkg::cell_ctl_t          ctl,
    input  logic [cwf_pkg::CHAR_W-1:0]  load_data,
    input  logic [cwf_pkg::CHAR_W-1:0]  right_data,
    output logic [cwf_pkg::CHAR_W-1:0]  data
);

    logic [cwf_pkg::CHAR_W-1:0] data_reg;
    logic [cwf_pkg::CHAR_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.shift) begin
            data_next = right_data;
        end else if (ctl.load) begin
            data_next = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> design/cwf_chain.sv
// cwf_chain: row of cwf_cell slots holding the current word; drains towards cell 0.
// Depends on cwf_pkg and cwf_cell.
module cwf_chain (
    input  logic                        aclk,
    input  logic                        shift,
    input  logic                        load_en,
    input  logic [cwf_pkg::IDX_W-1:0]   load_idx,
    input  logic [cwf_pkg::CHAR_W-1:0]  load_data,
    output logic [cwf_pkg::CHAR_W-1:0]  head
);

    logic [cwf_pkg::CHAR_W-1:0] cell_data [cwf_pkg::MAX_WORD];
    logic [cwf_pkg::CHAR_W-1:0] cell_right [cwf_pkg::MAX_WORD];
    cwf_pkg::cell_ctl_t         cell_ctl [cwf_pkg::MAX_WORD];

    for (genvar i = 0; i < cwf_pkg::MAX_WORD; i++) begin : g_cell
        assign cell_ctl[i].shift = shift;
        assign cell_ctl[i].load  = load_en && (load_idx == cwf_pkg::IDX_W'(i));
        if (i == cwf_pkg::MAX_WORD - 1) begin : g_last
            assign cell_right[i] = '0;
        end else begin : g_mid
            assign cell_right[i] = cell_data[i+1];
        end
        cwf_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl[i]),
            .load_data  (load_data),
            .right_data (cell_right[i]),
            .data       (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule
